[hdl/xmodem_crc_packet_receiver_core_defines.svh]
// Assertion macros shared by the XMODEM CRC receiver RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef XMODEM_CRC_PACKET_RECEIVER_CORE_DEFINES_SVH
`define XMODEM_CRC_PACKET_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define XCRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xcrc assertion failed");

// Next-cycle implication, disabled in reset
`define XCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xcrc assertion failed");

`endif

[hdl/xcrc_pkg.sv]
// Shared types, constants and the CRC-16 step for the XMODEM CRC receiver.
// No dependencies; imported by every module of the block.
`default_nettype none
package xcrc_pkg;

  localparam int LONG_PACKET_BYTES  = 1024;
  localparam int SHORT_PACKET_BYTES = 128;
  localparam int ADDR_W             = 24;
  localparam int CNT_W              = 11;
  localparam int CFG_DW             = ADDR_W;
  localparam int QDEPTH             = 2;
  localparam int QAW                = 1;

  localparam logic [CNT_W-1:0] LONG_CNT  = CNT_W'(LONG_PACKET_BYTES);
  localparam logic [CNT_W-1:0] SHORT_CNT = CNT_W'(SHORT_PACKET_BYTES);

  // Serial protocol bytes
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CAN = 8'h18;
  localparam logic [7:0] BYTE_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam logic [0:0] REG_MAX_ERRORS   = 1'b0;
  localparam logic [0:0] REG_BASE_ADDRESS = 1'b1;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic KIND_HOST  = 1'b0;
  localparam logic KIND_FLASH = 1'b1;

  localparam logic [3:0] FLAG_NONE    = 4'h0;
  localparam logic [3:0] FLAG_NUMBER  = 4'h1;
  localparam logic [3:0] FLAG_COMPL   = 4'h2;
  localparam logic [3:0] FLAG_CRC     = 4'h4;
  localparam logic [3:0] FLAG_TIMEOUT = 4'h8;

  localparam logic [1:0] SE_RUN   = 2'd0;
  localparam logic [1:0] SE_EOT   = 2'd1;
  localparam logic [1:0] SE_ABORT = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NUMBER,
    PH_COMPL,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  // Request from the front part; dbl asks for the result to be sent twice
  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic              erase;
    logic [3:0]        flags;
    logic              commit;
    logic [1:0]        send;
    logic              dbl;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic              erase;
    logic [3:0]        flags;
    logic              commit;
    logic [1:0]        send;
    logic              last;
  } res_t;

  // One byte of CRC-16, MSB first, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[hdl/xmodem_crc_packet_receiver_core.sv]
// Top level of the XMODEM 1K/CRC-16 receiver: front part, request queue, back part.
// Depends on xcrc_pkg, xcrc_front, xcrc_queue and xcrc_back.
//
//  Channel  Handshake        Payload
//  input    push / full      in_byte_value, in_mode
//  result   empty / pop      out_kind .. out_last (one result per pop)
//  config   cfg_we           cfg_index, cfg_data
//
// The front part takes one item per cycle while full is low; each item is
// classified and its CRC step done in that cycle. Its result is registered in
// a queue entry and then in the result register before it can be popped.
// A cancelling CAN pair occupies the result port for two pops.
// Reset is synchronous; there is no clearing pass.
// Stalls on pop back up through the two-entry queue and then raise full.
`default_nettype none
module xmodem_crc_packet_receiver_core
  import xcrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        in_byte_value,
  input  wire logic              in_mode,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   out_kind,
  output logic [7:0]             out_out_byte,
  output logic [ADDR_W-1:0]      out_write_address,
  output logic                   out_erase_before,
  output logic [3:0]             out_error_flags,
  output logic                   out_commit,
  output logic [1:0]             out_session_end,
  output logic                   out_last
);

  logic take, req_push, q_valid, q_take;
  cmd_t req_cmd, q_cmd;
  res_t res;

  assign take = push && !full;

  xcrc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_take       (take),
    .in_byte_value (in_byte_value),
    .in_mode       (in_mode),
    .req_push      (req_push),
    .req_cmd       (req_cmd)
  );

  xcrc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (req_push),
    .wr_cmd   (req_cmd),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  xcrc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_take  (q_take),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_kind          = res.kind;
  assign out_out_byte      = res.data;
  assign out_write_address = res.addr;
  assign out_erase_before  = res.erase;
  assign out_error_flags   = res.flags;
  assign out_commit        = res.commit;
  assign out_session_end   = res.send;
  assign out_last          = res.last;

endmodule
`default_nettype wire

[hdl/xcrc_front.sv]
// Front part: configuration registers, protocol state and classification of each input.
// Depends on xcrc_pkg; issues requests into xcrc_queue.
`default_nettype none
module xcrc_front
  import xcrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic              in_take,
  input  wire logic [7:0]        in_byte_value,
  input  wire logic              in_mode,
  output logic                   req_push,
  output cmd_t                   req_cmd
);

  logic [7:0]        max_err_r;
  logic [ADDR_W-1:0] base_addr_r;

  phase_t            phase_r, phase_nxt;
  logic [7:0]        exp_num_r, exp_num_nxt;
  logic [7:0]        rx_num_r, rx_num_nxt;
  logic [7:0]        rx_cmp_r, rx_cmp_nxt;
  logic [CNT_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic              long_r, long_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        crc_hi_r, crc_hi_nxt;
  logic [7:0]        err_cnt_r, err_cnt_nxt;
  logic [ADDR_W-1:0] addr_off_r, addr_off_nxt;
  logic              first_done_r, first_done_nxt;
  logic [1:0]        sess_r, sess_nxt;

  logic              live, cancel, is_tick, is_open, pkt_end;
  logic [CNT_W-1:0]  cnt_inc, pkt_size;
  logic [ADDR_W:0]   sum_a, sum_b, sum_off;
  logic [ADDR_W-1:0] addr_a, wr_addr, off_adv;
  logic [8:0]        num_sum;
  logic [3:0]        chk_flags;
  logic [7:0]        err_inc;

  // Decode the incoming item
  assign live     = (sess_r == SE_RUN);
  assign cancel   = (err_cnt_r >= max_err_r);
  assign is_tick  = (in_mode == MODE_TICK);
  assign is_open  = (in_byte_value == BYTE_SOH) || (in_byte_value == BYTE_STX);
  assign cnt_inc  = byte_cnt_r + CNT_W'(1);
  assign pkt_size = long_r ? LONG_CNT : SHORT_CNT;
  assign pkt_end  = (cnt_inc >= pkt_size);
  assign err_inc  = (err_cnt_r == 8'hFF) ? err_cnt_r : err_cnt_r + 8'd1;

  // Saturating flash address: base plus packet offset plus byte index
  assign sum_a   = {1'b0, base_addr_r} + {1'b0, addr_off_r};
  assign addr_a  = sum_a[ADDR_W] ? {ADDR_W{1'b1}} : sum_a[ADDR_W-1:0];
  assign sum_b   = {1'b0, addr_a} + (ADDR_W+1)'(byte_cnt_r);
  assign wr_addr = sum_b[ADDR_W] ? {ADDR_W{1'b1}} : sum_b[ADDR_W-1:0];
  assign sum_off = {1'b0, addr_off_r} + (ADDR_W+1)'(pkt_size);
  assign off_adv = sum_off[ADDR_W] ? {ADDR_W{1'b1}} : sum_off[ADDR_W-1:0];

  // Packet checks at the closing CRC byte
  assign num_sum = {1'b0, rx_num_r} + {1'b0, rx_cmp_r};
  always_comb begin
    chk_flags = FLAG_NONE;
    if (rx_num_r != exp_num_r) chk_flags = chk_flags | FLAG_NUMBER;
    if (num_sum != 9'd255) chk_flags = chk_flags | FLAG_COMPL;
    if ({crc_hi_r, in_byte_value} != crc_r) chk_flags = chk_flags | FLAG_CRC;
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_take && live) begin
      if (cancel || is_tick) begin
        phase_nxt = PH_HEADER;
      end else begin
        case (phase_r)
          PH_HEADER: if (is_open) phase_nxt = PH_NUMBER;
          PH_NUMBER: phase_nxt = PH_COMPL;
          PH_COMPL:  phase_nxt = PH_DATA;
          PH_DATA:   if (pkt_end) phase_nxt = PH_CRC_HI;
          PH_CRC_HI: phase_nxt = PH_CRC_LO;
          PH_CRC_LO: phase_nxt = PH_HEADER;
          default:   phase_nxt = PH_HEADER;
        endcase
      end
    end
  end

  // Requests and protocol counters
  always_comb begin
    exp_num_nxt    = exp_num_r;
    rx_num_nxt     = rx_num_r;
    rx_cmp_nxt     = rx_cmp_r;
    byte_cnt_nxt   = byte_cnt_r;
    long_nxt       = long_r;
    crc_nxt        = crc_r;
    crc_hi_nxt     = crc_hi_r;
    err_cnt_nxt    = err_cnt_r;
    addr_off_nxt   = addr_off_r;
    first_done_nxt = first_done_r;
    sess_nxt       = sess_r;
    req_push       = 1'b0;
    req_cmd        = '0;
    req_cmd.kind   = KIND_HOST;
    if (in_take && live) begin
      if (cancel) begin
        req_push     = 1'b1;
        req_cmd.data = BYTE_CAN;
        req_cmd.send = SE_ABORT;
        req_cmd.dbl  = 1'b1;
        sess_nxt     = SE_ABORT;
      end else if (is_tick) begin
        if (phase_r == PH_HEADER) begin
          req_push     = !first_done_r;
          req_cmd.data = BYTE_C;
        end else begin
          req_push       = 1'b1;
          req_cmd.data   = BYTE_NAK;
          req_cmd.flags  = FLAG_TIMEOUT;
          err_cnt_nxt    = err_inc;
          first_done_nxt = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_HEADER: begin
            if (is_open) begin
              long_nxt     = (in_byte_value == BYTE_STX);
              byte_cnt_nxt = '0;
              crc_nxt      = '0;
            end else if (in_byte_value == BYTE_EOT) begin
              req_push     = 1'b1;
              req_cmd.data = BYTE_ACK;
              req_cmd.send = SE_EOT;
              sess_nxt     = SE_EOT;
            end else if (in_byte_value == BYTE_CAN) begin
              sess_nxt = SE_ABORT;
            end else begin
              req_push     = 1'b1;
              req_cmd.data = BYTE_NAK;
              err_cnt_nxt  = err_inc;
            end
          end
          PH_NUMBER: rx_num_nxt = in_byte_value;
          PH_COMPL: begin
            rx_cmp_nxt   = in_byte_value;
            byte_cnt_nxt = '0;
            crc_nxt      = '0;
          end
          PH_DATA: begin
            req_push      = 1'b1;
            req_cmd.kind  = KIND_FLASH;
            req_cmd.data  = in_byte_value;
            req_cmd.addr  = wr_addr;
            req_cmd.erase = !first_done_r;
            crc_nxt       = crc_byte(crc_r, in_byte_value);
            byte_cnt_nxt  = cnt_inc;
          end
          PH_CRC_HI: crc_hi_nxt = in_byte_value;
          PH_CRC_LO: begin
            req_push       = 1'b1;
            first_done_nxt = 1'b1;
            if (chk_flags == FLAG_NONE) begin
              req_cmd.data   = BYTE_ACK;
              req_cmd.commit = 1'b1;
              exp_num_nxt    = exp_num_r + 8'd1;
              addr_off_nxt   = off_adv;
            end else begin
              req_cmd.data  = BYTE_NAK;
              req_cmd.flags = chk_flags;
              err_cnt_nxt   = err_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_err_r   <= 8'd3;
      base_addr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ERRORS:   max_err_r   <= cfg_data[7:0];
        REG_BASE_ADDRESS: base_addr_r <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance protocol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      exp_num_r    <= 8'd1;
      rx_num_r     <= '0;
      rx_cmp_r     <= '0;
      byte_cnt_r   <= '0;
      long_r       <= 1'b0;
      crc_r        <= '0;
      crc_hi_r     <= '0;
      err_cnt_r    <= '0;
      addr_off_r   <= '0;
      first_done_r <= 1'b0;
      sess_r       <= SE_RUN;
    end else begin
      phase_r      <= phase_nxt;
      exp_num_r    <= exp_num_nxt;
      rx_num_r     <= rx_num_nxt;
      rx_cmp_r     <= rx_cmp_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      long_r       <= long_nxt;
      crc_r        <= crc_nxt;
      crc_hi_r     <= crc_hi_nxt;
      err_cnt_r    <= err_cnt_nxt;
      addr_off_r   <= addr_off_nxt;
      first_done_r <= first_done_nxt;
      sess_r       <= sess_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/xcrc_queue.sv]
// Two-entry request queue between the front and back parts.
// Depends on xcrc_pkg and the assertion macros header.
`default_nettype none
`include "xmodem_crc_packet_receiver_core_defines.svh"
module xcrc_queue
  import xcrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic rd_en,
  output logic      rd_valid,
  output cmd_t      rd_cmd
);

  cmd_t             entry_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = entry_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + (QAW+1)'(1);
    if (!do_wr && do_rd) cnt_nxt = cnt_r - (QAW+1)'(1);
  end

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (do_wr) entry_r[wr_ptr_r] <= wr_cmd;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  `XCRC_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, 1'b1, cnt_r <= (QAW+1)'(QDEPTH))
  `XCRC_ASSERT_IMPL(a_q_push_not_full, clk, rst_n, wr_en, !full)
  `XCRC_ASSERT_NEXT(a_q_drain, clk, rst_n, do_rd && !do_wr, cnt_r == $past(cnt_r) - (QAW+1)'(1))

endmodule
`default_nettype wire

[hdl/xcrc_back.sv]
// Back part: expands requests into results and holds the result register.
// Depends on xcrc_pkg and the assertion macros header.
`default_nettype none
`include "xmodem_crc_packet_receiver_core_defines.svh"
module xcrc_back
  import xcrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_take,
  input  wire logic pop,
  output logic      empty,
  output res_t      res
);

  res_t res_r, res_nxt;
  logic valid_r, valid_nxt;
  logic second_r, second_nxt;
  logic load;

  assign load   = q_valid && (!valid_r || pop);
  assign empty  = !valid_r;
  assign res    = res_r;

  // Build the next result; a doubled request holds the queue head for one extra result
  always_comb begin
    res_nxt    = res_r;
    valid_nxt  = valid_r && !pop;
    second_nxt = second_r;
    q_take     = 1'b0;
    if (load) begin
      res_nxt.kind   = q_cmd.kind;
      res_nxt.data   = q_cmd.data;
      res_nxt.addr   = q_cmd.addr;
      res_nxt.erase  = q_cmd.erase;
      res_nxt.flags  = q_cmd.flags;
      res_nxt.commit = q_cmd.commit;
      res_nxt.send   = q_cmd.send;
      valid_nxt      = 1'b1;
      if (q_cmd.dbl && !second_r) begin
        res_nxt.last = 1'b0;
        second_nxt   = 1'b1;
      end else begin
        res_nxt.last = 1'b1;
        second_nxt   = 1'b0;
        q_take       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  `XCRC_ASSERT_IMPL(a_b_split_is_can, clk, rst_n, valid_r && !res_r.last, (res_r.data == BYTE_CAN) && (res_r.send == SE_ABORT))
  `XCRC_ASSERT_IMPL(a_b_head_held, clk, rst_n, second_r, q_valid && q_cmd.dbl)
  `XCRC_ASSERT_NEXT(a_b_second_last, clk, rst_n, load && !q_take, valid_r && !res_r.last)

endmodule
`default_nettype wire
